/* design/aesctr_pkg.sv */
// ----------------------------------------------------------------------------
// aesctr_pkg
// shared types, constants and aes-128 helper functions for the ctr byte stream
// ----------------------------------------------------------------------------
package aesctr_pkg;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);
  localparam logic [3:0] LAST_ROUND = 4'd10;

  localparam logic [1:0] REG_KEY_LOW  = 2'd0;
  localparam logic [1:0] REG_KEY_HIGH = 2'd1;
  localparam logic [1:0] REG_CTR_LOW  = 2'd2;
  localparam logic [1:0] REG_CTR_HIGH = 2'd3;

  typedef struct packed {
    logic [7:0]   data;
    logic [3:0]   pos;
    logic         new_blk;
    logic [127:0] ctr;
  } entry_t;

  typedef enum logic {
    BK_IDLE,
    BK_RUN
  } back_state_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] rcon(input logic [3:0] rnd);
    logic [7:0] r;
    unique case (rnd)
      4'd1:    r = 8'h01;
      4'd2:    r = 8'h02;
      4'd3:    r = 8'h04;
      4'd4:    r = 8'h08;
      4'd5:    r = 8'h10;
      4'd6:    r = 8'h20;
      4'd7:    r = 8'h40;
      4'd8:    r = 8'h80;
      4'd9:    r = 8'h1b;
      4'd10:   r = 8'h36;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  // byte i of every 128-bit block sits at bits 8i+7:8i
  function automatic logic [127:0] key_next(input logic [127:0] k, input logic [7:0] rc);
    logic [31:0]  t;
    logic [127:0] n;
    t = {SBOX[k[96+:8]], SBOX[k[120+:8]], SBOX[k[112+:8]], SBOX[k[104+:8]] ^ rc};
    n[31:0]   = k[31:0] ^ t;
    n[63:32]  = k[63:32] ^ n[31:0];
    n[95:64]  = k[95:64] ^ n[63:32];
    n[127:96] = k[127:96] ^ n[95:64];
    return n;
  endfunction

  function automatic logic [127:0] aes_round(input logic [127:0] s, input logic last);
    logic [7:0]   t [16];
    logic [127:0] r;
    logic [7:0]   a0, a1, a2, a3, al;
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        t[i + 4*c] = SBOX[s[8*(i + 4*((c + i) % 4)) +: 8]];
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = t[4*c];
      a1 = t[4*c + 1];
      a2 = t[4*c + 2];
      a3 = t[4*c + 3];
      al = a0 ^ a1 ^ a2 ^ a3;
      if (last) begin
        r[32*c +: 32] = {a3, a2, a1, a0};
      end else begin
        r[32*c +: 32] = {a3 ^ al ^ xtime(a3 ^ a0), a2 ^ al ^ xtime(a2 ^ a3),
                         a1 ^ al ^ xtime(a1 ^ a2), a0 ^ al ^ xtime(a0 ^ a1)};
      end
    end
    return r;
  endfunction

endpackage

/* design/aesctr_front.sv */
// ----------------------------------------------------------------------------
// aesctr_front
// accepts bytes, tracks position and running counter, tags block starts
// ----------------------------------------------------------------------------
module aesctr_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            in_data_byte,
  input  logic                  in_message_start,
  input  logic                  in_reload_counter,
  input  logic [127:0]          ctr_start,
  input  logic                  q_full,
  output logic                  q_push,
  output aesctr_pkg::entry_t    q_entry
);

  logic [127:0] ctr_r, ctr_nxt, ctr_eff;
  logic [3:0]   pos_r, pos_nxt, pos_eff;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    ctr_eff = in_reload_counter ? ctr_start : ctr_r;
    pos_eff = in_message_start ? 4'd0 : pos_r;
    q_entry.data    = in_data_byte;
    q_entry.pos     = pos_eff;
    q_entry.new_blk = (pos_eff == 4'd0);
    q_entry.ctr     = ctr_eff;
    ctr_nxt = ctr_r;
    pos_nxt = pos_r;
    if (q_push) begin
      ctr_nxt = q_entry.new_blk ? ctr_eff + 128'd1 : ctr_eff;
      pos_nxt = pos_eff + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctr_r <= '0;
      pos_r <= '0;
    end else begin
      ctr_r <= ctr_nxt;
      pos_r <= pos_nxt;
    end
  end

endmodule

/* design/aesctr_queue.sv */
// ----------------------------------------------------------------------------
// aesctr_queue
// short fifo between the front and the back
// ----------------------------------------------------------------------------
module aesctr_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  aesctr_pkg::entry_t    push_entry,
  output logic                  full,
  input  logic                  pop,
  output logic                  head_valid,
  output aesctr_pkg::entry_t    head
);

  aesctr_pkg::entry_t                 mem_r [aesctr_pkg::QDEPTH];
  logic [aesctr_pkg::QPTR_W-1:0]      wr_r, wr_nxt, rd_r, rd_nxt;
  logic [aesctr_pkg::QCNT_W-1:0]      cnt_r, cnt_nxt;

  assign full       = (cnt_r == aesctr_pkg::QCNT_W'(aesctr_pkg::QDEPTH));
  assign head_valid = (cnt_r != '0);
  assign head       = mem_r[rd_r];

  always_comb begin
    wr_nxt  = push ? wr_r + 1'b1 : wr_r;
    rd_nxt  = pop ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r + aesctr_pkg::QCNT_W'(push) - aesctr_pkg::QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

/* design/aesctr_back.sv */
// ----------------------------------------------------------------------------
// aesctr_back
// iterative aes-128 round engine, keystream xor and output register
// ----------------------------------------------------------------------------
module aesctr_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [127:0]          key,
  input  logic                  head_valid,
  input  aesctr_pkg::entry_t    head,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [7:0]            out_byte
);

  aesctr_pkg::back_state_t state_r, state_nxt;
  logic [127:0] st_r, st_nxt, rk_r, rk_nxt, mask_r, mask_nxt, rnd_out;
  logic [3:0]   rnd_r, rnd_nxt;
  logic         blk_ready_r, blk_ready_nxt;
  logic         out_valid_r, out_valid_nxt;
  logic [7:0]   out_byte_r, out_byte_nxt;
  logic         can_load, start_blk;

  assign can_load  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      aesctr_pkg::BK_IDLE: begin
        if (head_valid && head.new_blk && !blk_ready_r) begin
          state_nxt = aesctr_pkg::BK_RUN;
        end
      end
      aesctr_pkg::BK_RUN: begin
        if (rnd_r == aesctr_pkg::LAST_ROUND) begin
          state_nxt = aesctr_pkg::BK_IDLE;
        end
      end
      default: state_nxt = aesctr_pkg::BK_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    rk_nxt   = aesctr_pkg::key_next(rk_r, aesctr_pkg::rcon(rnd_r));
    rnd_out  = aesctr_pkg::aes_round(st_r, rnd_r == aesctr_pkg::LAST_ROUND) ^ rk_nxt;
    start_blk     = 1'b0;
    pop           = 1'b0;
    st_nxt        = st_r;
    mask_nxt      = mask_r;
    rnd_nxt       = rnd_r;
    blk_ready_nxt = blk_ready_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_byte_nxt  = out_byte_r;
    unique case (state_r)
      aesctr_pkg::BK_IDLE: begin
        start_blk = head_valid && head.new_blk && !blk_ready_r;
        pop       = head_valid && (!head.new_blk || blk_ready_r) && can_load;
        if (start_blk) begin
          st_nxt  = head.ctr ^ key;
          rnd_nxt = 4'd1;
        end
      end
      aesctr_pkg::BK_RUN: begin
        st_nxt  = rnd_out;
        rnd_nxt = rnd_r + 4'd1;
        if (rnd_r == aesctr_pkg::LAST_ROUND) begin
          mask_nxt      = rnd_out;
          blk_ready_nxt = 1'b1;
        end
      end
      default: ;
    endcase
    if (pop) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = head.data ^ mask_r[{head.pos, 3'b000} +: 8];
      if (head.new_blk) begin
        blk_ready_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_blk) begin
      rk_r <= key;
    end else if (state_r == aesctr_pkg::BK_RUN) begin
      rk_r <= rk_nxt;
    end
    st_r       <= st_nxt;
    rnd_r      <= rnd_nxt;
    out_byte_r <= out_byte_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= aesctr_pkg::BK_IDLE;
      blk_ready_r <= 1'b0;
      out_valid_r <= 1'b0;
      mask_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      blk_ready_r <= blk_ready_nxt;
      out_valid_r <= out_valid_nxt;
      mask_r      <= mask_nxt;
    end
  end

`ifndef SYNTHESIS
  a_no_pop_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == aesctr_pkg::BK_RUN) |-> !pop)
    else $error("byte released while a block is being encrypted");

  a_blk_before_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && head.new_blk) |-> blk_ready_r)
    else $error("block-start byte released before its mask");

  a_last_round_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == aesctr_pkg::BK_RUN && rnd_r == aesctr_pkg::LAST_ROUND)
      |=> (blk_ready_r && state_r == aesctr_pkg::BK_IDLE))
    else $error("mask not marked ready after last round");
`endif

endmodule

/* design/aes128_ctr_byte_stream_top.sv */
// ----------------------------------------------------------------------------
// aes128_ctr_byte_stream_top
// aes-128 counter mode byte stream with apb configuration
// ----------------------------------------------------------------------------
// Each accepted byte returns XORed with one keystream byte. Bytes that reuse
// the current mask pass without waiting for the round unit. The byte at
// position 0 of every 16-byte group waits at the head of the queue while the
// single round unit loads the counter block and runs the ten rounds. A
// four-entry queue lets input keep flowing while a block is encrypted. The
// round keys are derived on the fly from the key registers.
module aes128_ctr_byte_stream_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_message_start,
  input  logic        in_reload_counter,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  output logic [63:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [63:0] key_lo_r, key_hi_r, ctr_lo_r, ctr_hi_r;
  logic        wr_en, q_full, q_push, q_pop, head_valid;
  aesctr_pkg::entry_t q_entry, head;

  assign cfg_pready = 1'b1;
  assign wr_en = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_lo_r <= '0;
      key_hi_r <= '0;
      ctr_lo_r <= '0;
      ctr_hi_r <= '0;
    end else if (wr_en) begin
      unique case (cfg_paddr[4:3])
        aesctr_pkg::REG_KEY_LOW:  key_lo_r <= cfg_pwdata;
        aesctr_pkg::REG_KEY_HIGH: key_hi_r <= cfg_pwdata;
        aesctr_pkg::REG_CTR_LOW:  ctr_lo_r <= cfg_pwdata;
        aesctr_pkg::REG_CTR_HIGH: ctr_hi_r <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[4:3])
      aesctr_pkg::REG_KEY_LOW:  cfg_prdata = key_lo_r;
      aesctr_pkg::REG_KEY_HIGH: cfg_prdata = key_hi_r;
      aesctr_pkg::REG_CTR_LOW:  cfg_prdata = ctr_lo_r;
      aesctr_pkg::REG_CTR_HIGH: cfg_prdata = ctr_hi_r;
      default:                  cfg_prdata = '0;
    endcase
  end

  aesctr_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_byte      (in_data_byte),
    .in_message_start  (in_message_start),
    .in_reload_counter (in_reload_counter),
    .ctr_start         ({ctr_hi_r, ctr_lo_r}),
    .q_full            (q_full),
    .q_push            (q_push),
    .q_entry           (q_entry)
  );

  aesctr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head       (head)
  );

  aesctr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .key        ({key_hi_r, key_lo_r}),
    .head_valid (head_valid),
    .head       (head),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte)
  );

endmodule

/* tb/tb_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_checker
// watches the input and output transactions of the ctr byte stream, keeps its
// own aes-128 counter-mode model and compares every output byte in order
// ----------------------------------------------------------------------------
module tb_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_message_start,
  input  logic        in_reload_counter,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  out_byte,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  input  logic        cfg_pready,
  output int          fail_count,
  output int          pending
);

  localparam logic [7:0] SUBST [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };
  localparam logic [7:0] ROUND_CONST [10] = '{
    8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
  };

  logic [127:0] key_r, ctr_start_r, ctr_run_r, keystream_r;
  logic [3:0]   pos_r;
  logic [7:0]   expected_bytes [$];

  function automatic logic [7:0] gmul2(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  // fips-197 encryption, byte i of every block at bits 8i+7:8i
  function automatic logic [127:0] encrypt(input logic [127:0] key, input logic [127:0] blk);
    logic [31:0] w [44];
    logic [31:0] t;
    logic [7:0]  s [16];
    logic [7:0]  u [16];
    logic [7:0]  a0, a1, a2, a3, x;
    logic [127:0] res;
    for (int i = 0; i < 4; i++) begin
      w[i] = {key[32*i +: 8], key[32*i+8 +: 8], key[32*i+16 +: 8], key[32*i+24 +: 8]};
    end
    for (int i = 4; i < 44; i++) begin
      t = w[i-1];
      if (i % 4 == 0) begin
        t = {t[23:0], t[31:24]};
        t = {SUBST[t[31:24]] ^ ROUND_CONST[i/4 - 1], SUBST[t[23:16]], SUBST[t[15:8]],
             SUBST[t[7:0]]};
      end
      w[i] = w[i-4] ^ t;
    end
    for (int i = 0; i < 16; i++) s[i] = blk[8*i +: 8];
    for (int r = 0; r <= 10; r++) begin
      if (r > 0) begin
        for (int c = 0; c < 4; c++) begin
          for (int i = 0; i < 4; i++) u[i + 4*c] = SUBST[s[i + 4*((c + i) % 4)]];
        end
        for (int c = 0; c < 4; c++) begin
          a0 = u[4*c]; a1 = u[4*c+1]; a2 = u[4*c+2]; a3 = u[4*c+3];
          x = a0 ^ a1 ^ a2 ^ a3;
          if (r != 10) begin
            s[4*c]   = a0 ^ x ^ gmul2(a0 ^ a1);
            s[4*c+1] = a1 ^ x ^ gmul2(a1 ^ a2);
            s[4*c+2] = a2 ^ x ^ gmul2(a2 ^ a3);
            s[4*c+3] = a3 ^ x ^ gmul2(a3 ^ a0);
          end else begin
            s[4*c] = a0; s[4*c+1] = a1; s[4*c+2] = a2; s[4*c+3] = a3;
          end
        end
      end
      for (int c = 0; c < 4; c++) begin
        s[4*c]   ^= w[4*r+c][31:24];
        s[4*c+1] ^= w[4*r+c][23:16];
        s[4*c+2] ^= w[4*r+c][15:8];
        s[4*c+3] ^= w[4*r+c][7:0];
      end
    end
    for (int i = 0; i < 16; i++) res[8*i +: 8] = s[i];
    return res;
  endfunction

  always @(posedge clk) begin
    logic [127:0] ctr, ks;
    logic [3:0]   pos;
    logic [7:0]   exp_b;
    if (!rst_n) begin
      key_r <= '0; ctr_start_r <= '0; ctr_run_r <= '0; keystream_r <= '0; pos_r <= '0;
      expected_bytes.delete();
      fail_count <= 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[4:3])
          aesctr_pkg::REG_KEY_LOW:  key_r[63:0]         <= cfg_pwdata;
          aesctr_pkg::REG_KEY_HIGH: key_r[127:64]       <= cfg_pwdata;
          aesctr_pkg::REG_CTR_LOW:  ctr_start_r[63:0]   <= cfg_pwdata;
          aesctr_pkg::REG_CTR_HIGH: ctr_start_r[127:64] <= cfg_pwdata;
        endcase
      end
      if (in_valid && !in_stall) begin
        ctr = in_reload_counter ? ctr_start_r : ctr_run_r;
        pos = in_message_start ? 4'd0 : pos_r;
        ks = keystream_r;
        if (pos == 4'd0) begin
          ks = encrypt(key_r, ctr);
          ctr = ctr + 128'd1;
        end
        exp_b = in_data_byte ^ ks[8*pos +: 8];
        expected_bytes.push_back(exp_b);
        ctr_run_r <= ctr;
        keystream_r <= ks;
        pos_r <= pos + 4'd1;
      end
      if (out_valid && !out_stall) begin
        if (expected_bytes.size() == 0) begin
          $error("out_byte: unexpected transaction, actual %h", out_byte);
          fail_count <= fail_count + 1;
        end else begin
          exp_b = expected_bytes.pop_front();
          if (exp_b !== out_byte) begin
            $error("out_byte: expected %h actual %h", exp_b, out_byte);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

  assign pending = expected_bytes.size();

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// stimulus for the aes-128 ctr byte stream: directed messages, then random
// messages over several key and counter settings with random idling
// ----------------------------------------------------------------------------
module tb_top;

  localparam int IDLE_LIMIT = 20000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = '0;
  logic        in_message_start = 1'b0;
  logic        in_reload_counter = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_byte;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [4:0]  cfg_paddr = '0;
  logic [63:0] cfg_pwdata = '0;
  logic [63:0] cfg_prdata;
  logic        cfg_pready;
  int          fail_count;
  int          pending;
  int          idle_cycles = 0;
  bit          hold_off = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  aes128_ctr_byte_stream_top uut (.*);

  tb_checker checker_i (.*);

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_penable <= 1'b0;
    cfg_paddr <= {idx, 3'b000}; cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
  endtask

  task automatic send_byte(input logic [7:0] b, input logic start, input logic reload);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= b; in_message_start <= start; in_reload_counter <= reload;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_message(input int len, input bit reload);
    for (int i = 0; i < len; i++) begin
      send_byte(8'($urandom_range(0, 255)), i == 0 || $urandom_range(0, 199) == 0,
                (i == 0 && reload) || $urandom_range(0, 99) == 0);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic set_all(input logic [127:0] key, input logic [127:0] ctr);
    write_reg(aesctr_pkg::REG_KEY_LOW, key[63:0]);
    write_reg(aesctr_pkg::REG_KEY_HIGH, key[127:64]);
    write_reg(aesctr_pkg::REG_CTR_LOW, ctr[63:0]);
    write_reg(aesctr_pkg::REG_CTR_HIGH, ctr[127:64]);
  endtask

  // receiver idling, with one long hold-off
  always @(posedge clk) begin
    if (hold_off) begin
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < 25) ? 1'b1 :
                   (($urandom_range(0, 99) < 2) ? 1'b1 : 1'b0);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // no message start after reset, then position wrap in one long message
    for (int i = 0; i < 20; i++) send_byte(i == 0 ? 8'h00 : 8'hff, 1'b0, 1'b0);
    send_byte(8'ha5, 1'b1, 1'b1);
    send_byte(8'h5a, 1'b0, 1'b1);
    send_byte(8'h01, 1'b1, 1'b0);
    drain();
    // counter wrap from all ones, key all ones
    set_all({128{1'b1}}, {128{1'b1}});
    send_byte(8'h80, 1'b1, 1'b1);
    for (int i = 0; i < 17; i++) send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0);
    // new low key half written between messages takes effect at the next mask
    drain();
    write_reg(aesctr_pkg::REG_KEY_LOW, 64'h0123_4567_89ab_cdef);
    send_message(20, 1'b0);
    drain();
    // long receiver hold-off while input keeps flowing
    fork
      begin
        hold_off = 1'b1;
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end
      send_message(40, 1'b1);
    join
    drain();
    for (int phase = 0; phase < 6; phase++) begin
      if (phase == 5) begin
        set_all('0, '0);
      end else begin
        set_all({$urandom, $urandom, $urandom, $urandom},
                phase == 2 ? {{96{1'b1}}, 32'hffff_fff0} :
                             {$urandom, $urandom, $urandom, $urandom});
      end
      for (int n = 0; n < 220;) begin
        int len;
        len = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 48) : $urandom_range(49, 100);
        send_message(len, $urandom_range(0, 3) != 0);
        n += len;
      end
      drain();
    end
    repeat (50) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
